// ----- rtl/core/dma_channel_descriptor_engine_macros.svh -----
// Assertion macros used by the descriptor engine port checker.
`ifndef DMA_CHANNEL_DESCRIPTOR_ENGINE_MACROS_SVH
`define DMA_CHANNEL_DESCRIPTOR_ENGINE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DCDE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DCDE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/dcde_pkg.sv -----
// Types, constants and helper functions of the DMA channel descriptor engine.
package dcde_pkg;

   localparam int CHANNELS_DEFAULT   = 4;
   localparam int COUNT_BITS_DEFAULT = 16;
   localparam int ADDR_BITS_DEFAULT  = 32;

   localparam int CMD_BITS       = 3;
   localparam int CHAN_BITS      = 4;
   localparam int FIELD_ADDR_W   = 32;
   localparam int FIELD_COUNT_W  = 16;
   localparam int SIZE_BITS      = 2;
   localparam int STATUS_BITS    = 2;
   localparam int UNIT_BYTES_W   = 3;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_SET_TRANSFER = 3'd0,
      CMD_START        = 3'd1,
      CMD_REQUEST      = 3'd2,
      CMD_ENABLE       = 3'd3,
      CMD_DISABLE      = 3'd4,
      CMD_CLAIM        = 3'd5,
      CMD_QUERY        = 3'd6,
      CMD_CLEAR_ALL    = 3'd7
   } cmd_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK          = 2'd0,
      STATUS_BAD_CHANNEL = 2'd1,
      STATUS_BAD_VALUE   = 2'd2,
      STATUS_BUSY        = 2'd3
   } status_type;

   localparam logic [SIZE_BITS-1:0] SIZE_BYTE = 2'd0;
   localparam logic [SIZE_BITS-1:0] SIZE_HALF = 2'd1;
   localparam logic [SIZE_BITS-1:0] SIZE_WORD = 2'd2;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } ctrl_cmd_type;

   // Bytes in one unit; any code above halfword moves a word.
   function automatic logic [UNIT_BYTES_W-1:0] unit_bytes(input logic [SIZE_BITS-1:0] code);
      logic [UNIT_BYTES_W-1:0] bytes;
      unique case (code)
         SIZE_BYTE: bytes = 3'd1;
         SIZE_HALF: bytes = 3'd2;
         default:   bytes = 3'd4;
      endcase
      return bytes;
   endfunction

   function automatic logic [SIZE_BITS-1:0] size_code(input logic [SIZE_BITS-1:0] code);
      logic [SIZE_BITS-1:0] result;
      result = (code > SIZE_WORD) ? SIZE_WORD : code;
      return result;
   endfunction

endpackage

// ----- rtl/core/dma_channel_descriptor_engine.sv -----
// Top level of the multi-channel DMA descriptor engine.
// Each command on the req_ channel (set transfer, start, request, enable, disable,
// claim, query, clear all) names one channel and returns exactly one result on the
// rsp_ channel: a status, an optional unit transfer (address pair and size), a
// completion notice and, for query, the channel flags. Memory is moved outside.
// A command is captured in the cycle it is accepted and executed once the
// output register is free, when its result is loaded into that register and
// rsp_valid is set. The controller steps from its capture state to its execute
// state and back, so the block takes a new command only after the previous
// one has executed.
// A new command is accepted while the previous result still waits; if the
// receiver stalls, execution waits until the output register frees, so one
// result and one captured command can be held at once.
// Synchronous reset clears every channel descriptor and flag and empties the
// output register; clear all does the same for every channel.
module dma_channel_descriptor_engine #(
   parameter int CHANNELS   = dcde_pkg::CHANNELS_DEFAULT,
   parameter int COUNT_BITS = dcde_pkg::COUNT_BITS_DEFAULT,
   parameter int ADDR_BITS  = dcde_pkg::ADDR_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [dcde_pkg::CMD_BITS-1:0]       req_command,
   input  logic [dcde_pkg::CHAN_BITS-1:0]      req_channel,
   input  logic [dcde_pkg::FIELD_ADDR_W-1:0]   req_src_addr,
   input  logic [dcde_pkg::FIELD_ADDR_W-1:0]   req_dst_addr,
   input  logic [dcde_pkg::FIELD_COUNT_W-1:0]  req_byte_count,
   input  logic                                req_src_increment,
   input  logic                                req_dst_increment,
   input  logic [dcde_pkg::SIZE_BITS-1:0]      req_src_size,
   input  logic [dcde_pkg::SIZE_BITS-1:0]      req_dst_size,
   input  logic                                req_start_now,
   input  logic                                req_notify_enable,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [dcde_pkg::STATUS_BITS-1:0]    rsp_status,
   output logic                                rsp_xfer_valid,
   output logic [dcde_pkg::FIELD_ADDR_W-1:0]   rsp_xfer_src,
   output logic [dcde_pkg::FIELD_ADDR_W-1:0]   rsp_xfer_dst,
   output logic [dcde_pkg::SIZE_BITS-1:0]      rsp_xfer_size,
   output logic                                rsp_done_notice,
   output logic                                rsp_chan_enabled,
   output logic                                rsp_chan_done,
   output logic                                rsp_chan_claimed
);
   import dcde_pkg::*;

   ctrl_cmd_type ctrl_cmd;

   dcde_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctrl_cmd  (ctrl_cmd)
   );

   dcde_datapath #(
      .CHANNELS   (CHANNELS),
      .COUNT_BITS (COUNT_BITS),
      .ADDR_BITS  (ADDR_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctrl_cmd          (ctrl_cmd),
      .req_command       (req_command),
      .req_channel       (req_channel),
      .req_src_addr      (req_src_addr),
      .req_dst_addr      (req_dst_addr),
      .req_byte_count    (req_byte_count),
      .req_src_increment (req_src_increment),
      .req_dst_increment (req_dst_increment),
      .req_src_size      (req_src_size),
      .req_dst_size      (req_dst_size),
      .req_start_now     (req_start_now),
      .req_notify_enable (req_notify_enable),
      .rsp_status        (rsp_status),
      .rsp_xfer_valid    (rsp_xfer_valid),
      .rsp_xfer_src      (rsp_xfer_src),
      .rsp_xfer_dst      (rsp_xfer_dst),
      .rsp_xfer_size     (rsp_xfer_size),
      .rsp_done_notice   (rsp_done_notice),
      .rsp_chan_enabled  (rsp_chan_enabled),
      .rsp_chan_done     (rsp_chan_done),
      .rsp_chan_claimed  (rsp_chan_claimed)
   );

endmodule

// ----- rtl/core/dcde_ctrl.sv -----
// Controller state machine that sequences capture, execution and result handoff.
module dcde_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output dcde_pkg::ctrl_cmd_type ctrl_cmd
);
   import dcde_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in         = state_ff;
      req_ready        = 1'b0;
      ctrl_cmd.capture = 1'b0;
      ctrl_cmd.execute = 1'b0;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl_cmd.capture = 1'b1;
               state_in         = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               ctrl_cmd.execute = 1'b1;
               rsp_valid_in     = 1'b1;
               state_in         = ST_IDLE;
            end
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/core/dcde_datapath.sv -----
// Datapath holding the captured command, the per-channel descriptors and the result register.
module dcde_datapath #(
   parameter int CHANNELS   = dcde_pkg::CHANNELS_DEFAULT,
   parameter int COUNT_BITS = dcde_pkg::COUNT_BITS_DEFAULT,
   parameter int ADDR_BITS  = dcde_pkg::ADDR_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  dcde_pkg::ctrl_cmd_type              ctrl_cmd,
   input  logic [dcde_pkg::CMD_BITS-1:0]       req_command,
   input  logic [dcde_pkg::CHAN_BITS-1:0]      req_channel,
   input  logic [dcde_pkg::FIELD_ADDR_W-1:0]   req_src_addr,
   input  logic [dcde_pkg::FIELD_ADDR_W-1:0]   req_dst_addr,
   input  logic [dcde_pkg::FIELD_COUNT_W-1:0]  req_byte_count,
   input  logic                                req_src_increment,
   input  logic                                req_dst_increment,
   input  logic [dcde_pkg::SIZE_BITS-1:0]      req_src_size,
   input  logic [dcde_pkg::SIZE_BITS-1:0]      req_dst_size,
   input  logic                                req_start_now,
   input  logic                                req_notify_enable,
   output logic [dcde_pkg::STATUS_BITS-1:0]    rsp_status,
   output logic                                rsp_xfer_valid,
   output logic [dcde_pkg::FIELD_ADDR_W-1:0]   rsp_xfer_src,
   output logic [dcde_pkg::FIELD_ADDR_W-1:0]   rsp_xfer_dst,
   output logic [dcde_pkg::SIZE_BITS-1:0]      rsp_xfer_size,
   output logic                                rsp_done_notice,
   output logic                                rsp_chan_enabled,
   output logic                                rsp_chan_done,
   output logic                                rsp_chan_claimed
);
   import dcde_pkg::*;

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // Captured command.
   cmd_type                  cmd_ff;
   logic [CHAN_BITS-1:0]     chan_ff;
   logic [FIELD_ADDR_W-1:0]  src_ff, dst_ff;
   logic [FIELD_COUNT_W-1:0] count_ff;
   logic                     sinc_ff, dinc_ff, start_now_ff, notify_ff;
   logic [SIZE_BITS-1:0]     ssize_ff, dsize_ff;

   // Per-channel descriptors.
   logic [ADDR_BITS-1:0]  src_ptr_ff    [CHANNELS];
   logic [ADDR_BITS-1:0]  dst_ptr_ff    [CHANNELS];
   logic [COUNT_BITS-1:0] rem_ff        [CHANNELS];
   logic                  sstep_ff      [CHANNELS];
   logic                  dstep_ff      [CHANNELS];
   logic [SIZE_BITS-1:0]  sunit_ff      [CHANNELS];
   logic [SIZE_BITS-1:0]  dunit_ff      [CHANNELS];
   logic                  start_opt_ff  [CHANNELS];
   logic                  done_ff       [CHANNELS];
   logic                  enable_ff     [CHANNELS];
   logic                  claim_ff      [CHANNELS];
   logic                  notify_flag_ff[CHANNELS];

   logic [ADDR_BITS-1:0]  src_ptr_in, dst_ptr_in;
   logic [COUNT_BITS-1:0] rem_in;
   logic                  sstep_in, dstep_in, start_opt_in;
   logic                  done_in, enable_in, claim_in, notify_in;
   logic [SIZE_BITS-1:0]  sunit_in, dunit_in;
   logic                  chan_wr, clear_all;

   // Result register.
   status_type              status_ff, status_in;
   logic                    xvalid_ff, xvalid_in;
   logic [FIELD_ADDR_W-1:0] xsrc_ff, xsrc_in, xdst_ff, xdst_in;
   logic [SIZE_BITS-1:0]    xsize_ff, xsize_in;
   logic                    dnotice_ff, dnotice_in;
   logic                    q_en_ff, q_en_in, q_done_ff, q_done_in, q_claim_ff, q_claim_in;

   logic                    chan_ok;
   logic [IDX_W-1:0]        idx;
   logic [UNIT_BYTES_W-1:0] sub, dub;
   logic                    serve_done;
   logic [COUNT_BITS-1:0]   serve_rem;
   logic [ADDR_BITS-1:0]    serve_src, serve_dst;

   always_ff @(posedge clock) begin
      if (ctrl_cmd.capture) begin
         cmd_ff       <= cmd_type'(req_command);
         chan_ff      <= req_channel;
         src_ff       <= req_src_addr;
         dst_ff       <= req_dst_addr;
         count_ff     <= req_byte_count;
         sinc_ff      <= req_src_increment;
         dinc_ff      <= req_dst_increment;
         ssize_ff     <= req_src_size;
         dsize_ff     <= req_dst_size;
         start_now_ff <= req_start_now;
         notify_ff    <= req_notify_enable;
      end
   end

   assign chan_ok = ({1'b0, chan_ff} < (CHAN_BITS + 1)'(CHANNELS));
   assign idx     = chan_ff[IDX_W-1:0];

   assign sub        = unit_bytes(sunit_ff[idx]);
   assign dub        = unit_bytes(dunit_ff[idx]);
   assign serve_done = (rem_ff[idx] <= COUNT_BITS'(sub));
   assign serve_rem  = serve_done ? rem_ff[idx] : rem_ff[idx] - COUNT_BITS'(sub);
   assign serve_src  = sstep_ff[idx] ? src_ptr_ff[idx] + ADDR_BITS'(sub) : src_ptr_ff[idx];
   assign serve_dst  = dstep_ff[idx] ? dst_ptr_ff[idx] + ADDR_BITS'(dub) : dst_ptr_ff[idx];

   always_comb begin
      src_ptr_in   = src_ptr_ff[idx];
      dst_ptr_in   = dst_ptr_ff[idx];
      rem_in       = rem_ff[idx];
      sstep_in     = sstep_ff[idx];
      dstep_in     = dstep_ff[idx];
      sunit_in     = sunit_ff[idx];
      dunit_in     = dunit_ff[idx];
      start_opt_in = start_opt_ff[idx];
      done_in      = done_ff[idx];
      enable_in    = enable_ff[idx];
      claim_in     = claim_ff[idx];
      notify_in    = notify_flag_ff[idx];
      chan_wr      = 1'b0;
      clear_all    = 1'b0;
      status_in    = STATUS_OK;
      xvalid_in    = 1'b0;
      xsrc_in      = '0;
      xdst_in      = '0;
      xsize_in     = SIZE_BYTE;
      dnotice_in   = 1'b0;
      q_en_in      = 1'b0;
      q_done_in    = 1'b0;
      q_claim_in   = 1'b0;
      if (cmd_ff == CMD_CLEAR_ALL) begin
         clear_all = 1'b1;
      end else if (!chan_ok) begin
         status_in = STATUS_BAD_CHANNEL;
      end else begin
         unique case (cmd_ff)
            CMD_SET_TRANSFER: begin
               if (src_ff == '0 && dst_ff == '0) begin
                  status_in = STATUS_BAD_VALUE;
               end else begin
                  chan_wr      = 1'b1;
                  src_ptr_in   = src_ff[ADDR_BITS-1:0];
                  dst_ptr_in   = dst_ff[ADDR_BITS-1:0];
                  rem_in       = COUNT_BITS'(count_ff);
                  sstep_in     = sinc_ff;
                  dstep_in     = dinc_ff;
                  sunit_in     = ssize_ff;
                  dunit_in     = dsize_ff;
                  start_opt_in = start_now_ff;
               end
            end
            CMD_START: begin
               if (rem_ff[idx] == '0) begin
                  status_in = STATUS_BAD_VALUE;
               end else begin
                  chan_wr   = 1'b1;
                  done_in   = 1'b0;
                  notify_in = notify_ff;
                  if (start_opt_ff[idx]) begin
                     done_in    = serve_done;
                     rem_in     = serve_rem;
                     src_ptr_in = serve_src;
                     dst_ptr_in = serve_dst;
                     xvalid_in  = 1'b1;
                     xsrc_in    = FIELD_ADDR_W'(src_ptr_ff[idx]);
                     xdst_in    = FIELD_ADDR_W'(dst_ptr_ff[idx]);
                     xsize_in   = size_code(sunit_ff[idx]);
                  end
               end
            end
            CMD_REQUEST: begin
               chan_wr = 1'b1;
               if (done_ff[idx]) begin
                  enable_in  = 1'b0;
                  dnotice_in = notify_flag_ff[idx];
               end else begin
                  done_in    = serve_done;
                  rem_in     = serve_rem;
                  src_ptr_in = serve_src;
                  dst_ptr_in = serve_dst;
                  xvalid_in  = 1'b1;
                  xsrc_in    = FIELD_ADDR_W'(src_ptr_ff[idx]);
                  xdst_in    = FIELD_ADDR_W'(dst_ptr_ff[idx]);
                  xsize_in   = size_code(sunit_ff[idx]);
               end
            end
            CMD_ENABLE: begin
               chan_wr   = 1'b1;
               enable_in = 1'b1;
            end
            CMD_DISABLE: begin
               chan_wr   = 1'b1;
               enable_in = 1'b0;
            end
            CMD_CLAIM: begin
               if (claim_ff[idx]) begin
                  status_in = STATUS_BUSY;
               end else begin
                  chan_wr  = 1'b1;
                  claim_in = 1'b1;
               end
            end
            CMD_QUERY: begin
               q_en_in    = enable_ff[idx];
               q_done_in  = done_ff[idx];
               q_claim_in = claim_ff[idx];
            end
            CMD_CLEAR_ALL: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (ctrl_cmd.execute && clear_all)) begin
         for (int i = 0; i < CHANNELS; i++) begin
            src_ptr_ff[i]     <= '0;
            dst_ptr_ff[i]     <= '0;
            rem_ff[i]         <= '0;
            sstep_ff[i]       <= 1'b0;
            dstep_ff[i]       <= 1'b0;
            sunit_ff[i]       <= '0;
            dunit_ff[i]       <= '0;
            start_opt_ff[i]   <= 1'b0;
            done_ff[i]        <= 1'b0;
            enable_ff[i]      <= 1'b0;
            claim_ff[i]       <= 1'b0;
            notify_flag_ff[i] <= 1'b0;
         end
      end else if (ctrl_cmd.execute && chan_wr) begin
         src_ptr_ff[idx]     <= src_ptr_in;
         dst_ptr_ff[idx]     <= dst_ptr_in;
         rem_ff[idx]         <= rem_in;
         sstep_ff[idx]       <= sstep_in;
         dstep_ff[idx]       <= dstep_in;
         sunit_ff[idx]       <= sunit_in;
         dunit_ff[idx]       <= dunit_in;
         start_opt_ff[idx]   <= start_opt_in;
         done_ff[idx]        <= done_in;
         enable_ff[idx]      <= enable_in;
         claim_ff[idx]       <= claim_in;
         notify_flag_ff[idx] <= notify_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.execute) begin
         status_ff  <= status_in;
         xvalid_ff  <= xvalid_in;
         xsrc_ff    <= xsrc_in;
         xdst_ff    <= xdst_in;
         xsize_ff   <= xsize_in;
         dnotice_ff <= dnotice_in;
         q_en_ff    <= q_en_in;
         q_done_ff  <= q_done_in;
         q_claim_ff <= q_claim_in;
      end
   end

   assign rsp_status       = status_ff;
   assign rsp_xfer_valid   = xvalid_ff;
   assign rsp_xfer_src     = xsrc_ff;
   assign rsp_xfer_dst     = xdst_ff;
   assign rsp_xfer_size    = xsize_ff;
   assign rsp_done_notice  = dnotice_ff;
   assign rsp_chan_enabled = q_en_ff;
   assign rsp_chan_done    = q_done_ff;
   assign rsp_chan_claimed = q_claim_ff;

endmodule

// ----- rtl/core/dcde_checker.sv -----
// Port-level assertions for the DMA descriptor engine and their bind to the top level.
`include "dma_channel_descriptor_engine_macros.svh"

module dcde_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [dcde_pkg::STATUS_BITS-1:0]    rsp_status,
   input logic                                rsp_xfer_valid,
   input logic [dcde_pkg::FIELD_ADDR_W-1:0]   rsp_xfer_src,
   input logic [dcde_pkg::FIELD_ADDR_W-1:0]   rsp_xfer_dst,
   input logic [dcde_pkg::SIZE_BITS-1:0]      rsp_xfer_size,
   input logic                                rsp_done_notice
);
   import dcde_pkg::*;

   `DCDE_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready,
      !req_ready, "Command accepted while the previous one was still being captured.")

   `DCDE_ASSERT_SAME(a_rsp_after_accept, clock, reset, $rose(rsp_valid),
      $past(req_valid && req_ready, 2), "Result appeared without an accepted command.")

   `DCDE_ASSERT_SAME(a_idle_payload_zero, clock, reset, rsp_valid && !rsp_xfer_valid,
      rsp_xfer_src == '0 && rsp_xfer_dst == '0 && rsp_xfer_size == SIZE_BYTE,
      "Transfer fields are nonzero on a result without a transfer.")

   `DCDE_ASSERT_SAME(a_error_no_action, clock, reset,
      rsp_valid && rsp_status != STATUS_OK,
      !rsp_xfer_valid && !rsp_done_notice,
      "A failed command issued a transfer or a completion notice.")

   `DCDE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_status) && $stable(rsp_xfer_src),
      "Stalled result was dropped or changed.")

endmodule

bind dma_channel_descriptor_engine dcde_checker u_dcde_checker (.*);

// ----- verif/dma_channel_descriptor_engine_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard that tracks channel state, predicts each response and compares it field by field.
module dma_channel_descriptor_engine_checker
   import dcde_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic [CMD_BITS-1:0]       req_command,
   input  logic [CHAN_BITS-1:0]      req_channel,
   input  logic [FIELD_ADDR_W-1:0]   req_src_addr,
   input  logic [FIELD_ADDR_W-1:0]   req_dst_addr,
   input  logic [FIELD_COUNT_W-1:0]  req_byte_count,
   input  logic                      req_src_increment,
   input  logic                      req_dst_increment,
   input  logic [SIZE_BITS-1:0]      req_src_size,
   input  logic [SIZE_BITS-1:0]      req_dst_size,
   input  logic                      req_start_now,
   input  logic                      req_notify_enable,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [STATUS_BITS-1:0]    rsp_status,
   input  logic                      rsp_xfer_valid,
   input  logic [FIELD_ADDR_W-1:0]   rsp_xfer_src,
   input  logic [FIELD_ADDR_W-1:0]   rsp_xfer_dst,
   input  logic [SIZE_BITS-1:0]      rsp_xfer_size,
   input  logic                      rsp_done_notice,
   input  logic                      rsp_chan_enabled,
   input  logic                      rsp_chan_done,
   input  logic                      rsp_chan_claimed,
   output int                        fail_count,
   output int                        pending,
   output int                        checked,
   output int                        units_issued,
   output int                        notices
);

   localparam int NCHAN = CHANNELS_DEFAULT;

   typedef struct packed {
      status_type               status;
      logic                     xfer_valid;
      logic [FIELD_ADDR_W-1:0]  xfer_src;
      logic [FIELD_ADDR_W-1:0]  xfer_dst;
      logic [SIZE_BITS-1:0]     xfer_size;
      logic                     done_notice;
      logic                     chan_enabled;
      logic                     chan_done;
      logic                     chan_claimed;
   } dma_result_type;

   logic [ADDR_BITS_DEFAULT-1:0]  src_ptr    [NCHAN];
   logic [ADDR_BITS_DEFAULT-1:0]  dst_ptr    [NCHAN];
   logic [COUNT_BITS_DEFAULT-1:0] bytes_left [NCHAN];
   logic                          src_step   [NCHAN];
   logic                          dst_step   [NCHAN];
   logic [SIZE_BITS-1:0]          src_code   [NCHAN];
   logic [SIZE_BITS-1:0]          dst_code   [NCHAN];
   logic                          auto_issue [NCHAN];
   logic                          is_done    [NCHAN];
   logic                          is_enabled [NCHAN];
   logic                          is_claimed [NCHAN];
   logic                          wants_note [NCHAN];

   dma_result_type expected_results[$];

   function automatic int unsigned unit_len(input logic [SIZE_BITS-1:0] code);
      case (code)
         SIZE_BYTE: return 1;
         SIZE_HALF: return 2;
         default:   return 4;
      endcase
   endfunction

   function automatic void clear_channels();
      for (int i = 0; i < NCHAN; i++) begin
         src_ptr[i]    = '0;
         dst_ptr[i]    = '0;
         bytes_left[i] = '0;
         src_step[i]   = 1'b0;
         dst_step[i]   = 1'b0;
         src_code[i]   = SIZE_BYTE;
         dst_code[i]   = SIZE_BYTE;
         auto_issue[i] = 1'b0;
         is_done[i]    = 1'b0;
         is_enabled[i] = 1'b0;
         is_claimed[i] = 1'b0;
         wants_note[i] = 1'b0;
      end
   endfunction

   // The last unit marks the channel done and is still issued; the count never wraps.
   function automatic void issue_unit(input int ch, inout dma_result_type r);
      int unsigned len;
      len = unit_len(src_code[ch]);
      if (bytes_left[ch] <= len) begin
         is_done[ch] = 1'b1;
      end
      if (!is_done[ch]) begin
         bytes_left[ch] = COUNT_BITS_DEFAULT'(bytes_left[ch] - len);
      end
      r.xfer_valid = 1'b1;
      r.xfer_src   = src_ptr[ch];
      r.xfer_dst   = dst_ptr[ch];
      r.xfer_size  = (src_code[ch] > SIZE_WORD) ? SIZE_WORD : src_code[ch];
      if (src_step[ch]) begin
         src_ptr[ch] = ADDR_BITS_DEFAULT'(src_ptr[ch] + len);
      end
      if (dst_step[ch]) begin
         dst_ptr[ch] = ADDR_BITS_DEFAULT'(dst_ptr[ch] + unit_len(dst_code[ch]));
      end
   endfunction

   task automatic check_field(input string name, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (want_v !== got_v) begin
         fail_count++;
         if (fail_count <= 10) begin
            $display("%0t: response %0d, %s: expected %h, got %h",
                     $time, checked, name, want_v, got_v);
         end
      end
   endtask

   always @(posedge clock) begin : scoreboard
      dma_result_type want;
      cmd_type        cmd;
      int             ch;
      if (reset) begin
         clear_channels();
         expected_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            checked++;
            if (expected_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("%0t: response with no command outstanding, status %0d",
                           $time, rsp_status);
               end
            end else begin
               want = expected_results.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_status));
               check_field("xfer_valid", 32'(want.xfer_valid), 32'(rsp_xfer_valid));
               check_field("xfer_src", want.xfer_src, rsp_xfer_src);
               check_field("xfer_dst", want.xfer_dst, rsp_xfer_dst);
               check_field("xfer_size", 32'(want.xfer_size), 32'(rsp_xfer_size));
               check_field("done_notice", 32'(want.done_notice), 32'(rsp_done_notice));
               check_field("chan_enabled", 32'(want.chan_enabled), 32'(rsp_chan_enabled));
               check_field("chan_done", 32'(want.chan_done), 32'(rsp_chan_done));
               check_field("chan_claimed", 32'(want.chan_claimed), 32'(rsp_chan_claimed));
            end
         end
         if (req_valid && req_ready) begin
            want = '0;
            cmd  = cmd_type'(req_command);
            ch   = int'(req_channel);
            if (cmd == CMD_CLEAR_ALL) begin
               clear_channels();
            end else if (ch >= NCHAN) begin
               want.status = STATUS_BAD_CHANNEL;
            end else begin
               case (cmd)
                  CMD_SET_TRANSFER: begin
                     if (req_src_addr == '0 && req_dst_addr == '0) begin
                        want.status = STATUS_BAD_VALUE;
                     end else begin
                        src_ptr[ch]    = req_src_addr;
                        dst_ptr[ch]    = req_dst_addr;
                        bytes_left[ch] = req_byte_count;
                        src_step[ch]   = req_src_increment;
                        dst_step[ch]   = req_dst_increment;
                        src_code[ch]   = req_src_size;
                        dst_code[ch]   = req_dst_size;
                        auto_issue[ch] = req_start_now;
                     end
                  end
                  CMD_START: begin
                     if (bytes_left[ch] == '0) begin
                        want.status = STATUS_BAD_VALUE;
                     end else begin
                        is_done[ch]    = 1'b0;
                        wants_note[ch] = req_notify_enable;
                        if (auto_issue[ch]) begin
                           issue_unit(ch, want);
                        end
                     end
                  end
                  CMD_REQUEST: begin
                     if (is_done[ch]) begin
                        is_enabled[ch]   = 1'b0;
                        want.done_notice = wants_note[ch];
                     end else begin
                        issue_unit(ch, want);
                     end
                  end
                  CMD_ENABLE: begin
                     is_enabled[ch] = 1'b1;
                  end
                  CMD_DISABLE: begin
                     is_enabled[ch] = 1'b0;
                  end
                  CMD_CLAIM: begin
                     if (is_claimed[ch]) begin
                        want.status = STATUS_BUSY;
                     end else begin
                        is_claimed[ch] = 1'b1;
                     end
                  end
                  CMD_QUERY: begin
                     want.chan_enabled = is_enabled[ch];
                     want.chan_done    = is_done[ch];
                     want.chan_claimed = is_claimed[ch];
                  end
                  default: ;
               endcase
            end
            if (want.xfer_valid) begin
               units_issued++;
            end
            if (want.done_notice) begin
               notices++;
            end
            expected_results.push_back(want);
         end
      end
      pending = expected_results.size();
   end

endmodule

// ----- verif/dma_channel_descriptor_engine_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the DMA descriptor engine: clock, reset, command stimulus and verdict.
module dma_channel_descriptor_engine_tb;
   import dcde_pkg::*;

   localparam int NCHAN       = CHANNELS_DEFAULT;
   localparam int ITEMS       = 1700;
   localparam int HOLD_CYCLES = 200;
   localparam int IDLE_LIMIT  = 2000;
   localparam int TAIL_CYCLES = 8;

   typedef struct {
      cmd_type                  command;
      logic [CHAN_BITS-1:0]     channel;
      logic [FIELD_ADDR_W-1:0]  src_addr;
      logic [FIELD_ADDR_W-1:0]  dst_addr;
      logic [FIELD_COUNT_W-1:0] byte_count;
      logic                     src_increment;
      logic                     dst_increment;
      logic [SIZE_BITS-1:0]     src_size;
      logic [SIZE_BITS-1:0]     dst_size;
      logic                     start_now;
      logic                     notify_enable;
   } dma_command_type;

   typedef enum {RX_FREE, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [CMD_BITS-1:0]       req_command;
   logic [CHAN_BITS-1:0]      req_channel;
   logic [FIELD_ADDR_W-1:0]   req_src_addr;
   logic [FIELD_ADDR_W-1:0]   req_dst_addr;
   logic [FIELD_COUNT_W-1:0]  req_byte_count;
   logic                      req_src_increment;
   logic                      req_dst_increment;
   logic [SIZE_BITS-1:0]      req_src_size;
   logic [SIZE_BITS-1:0]      req_dst_size;
   logic                      req_start_now;
   logic                      req_notify_enable;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [STATUS_BITS-1:0]    rsp_status;
   logic                      rsp_xfer_valid;
   logic [FIELD_ADDR_W-1:0]   rsp_xfer_src;
   logic [FIELD_ADDR_W-1:0]   rsp_xfer_dst;
   logic [SIZE_BITS-1:0]      rsp_xfer_size;
   logic                      rsp_done_notice;
   logic                      rsp_chan_enabled;
   logic                      rsp_chan_done;
   logic                      rsp_chan_claimed;

   int fail_count;
   int pending;
   int checked;
   int units_issued;
   int notices;

   int sent        = 0;
   int burst_left  = 0;
   int idle_cycles = 0;
   int cmd_seen [8];

   dma_channel_descriptor_engine u_dut (.*);

   dma_channel_descriptor_engine_checker u_checker (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("Watchdog: no transfer for %0d cycles, %0d responses outstanding",
                  IDLE_LIMIT, pending);
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic dma_command_type make_cmd(input cmd_type cmd, input int ch);
      dma_command_type c;
      c.command  = cmd;
      c.channel  = ch[CHAN_BITS-1:0];
      c.src_addr = ($urandom_range(0, 7) == 0) ? '0 : $urandom;
      c.dst_addr = ($urandom_range(0, 7) == 0) ? '0 : $urandom;
      case ($urandom_range(0, 2))
         0:       c.byte_count = '0;
         1:       c.byte_count = FIELD_COUNT_W'($urandom_range(1, 64));
         default: c.byte_count = FIELD_COUNT_W'($urandom_range(0, 16'hFFFF));
      endcase
      c.src_increment = 1'($urandom_range(0, 1));
      c.dst_increment = 1'($urandom_range(0, 1));
      c.src_size      = SIZE_BITS'($urandom_range(0, 3));
      c.dst_size      = SIZE_BITS'($urandom_range(0, 3));
      c.start_now     = 1'($urandom_range(0, 1));
      c.notify_enable = 1'($urandom_range(0, 1));
      return c;
   endfunction

   function automatic dma_command_type make_setup(input int ch,
                                                  input logic [FIELD_ADDR_W-1:0] src,
                                                  input logic [FIELD_ADDR_W-1:0] dst,
                                                  input logic [FIELD_COUNT_W-1:0] count,
                                                  input logic src_inc, input logic dst_inc,
                                                  input logic [SIZE_BITS-1:0] src_sz,
                                                  input logic [SIZE_BITS-1:0] dst_sz,
                                                  input logic now);
      dma_command_type c;
      c               = make_cmd(CMD_SET_TRANSFER, ch);
      c.src_addr      = src;
      c.dst_addr      = dst;
      c.byte_count    = count;
      c.src_increment = src_inc;
      c.dst_increment = dst_inc;
      c.src_size      = src_sz;
      c.dst_size      = dst_sz;
      c.start_now     = now;
      return c;
   endfunction

   // Clear all is kept rare so that channel state can build up.
   function automatic dma_command_type noise_item();
      cmd_type cmd;
      cmd = cmd_type'($urandom_range(0, 7));
      if (cmd == CMD_CLEAR_ALL && $urandom_range(0, 3) != 0) begin
         cmd = CMD_QUERY;
      end
      return make_cmd(cmd, $urandom_range(0, 15));
   endfunction

   task automatic send(input dma_command_type c);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_valid         <= 1'b1;
      req_command       <= c.command;
      req_channel       <= c.channel;
      req_src_addr      <= c.src_addr;
      req_dst_addr      <= c.dst_addr;
      req_byte_count    <= c.byte_count;
      req_src_increment <= c.src_increment;
      req_dst_increment <= c.dst_increment;
      req_src_size      <= c.src_size;
      req_dst_size      <= c.dst_size;
      req_start_now     <= c.start_now;
      req_notify_enable <= c.notify_enable;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      sent++;
      cmd_seen[c.command]++;
      @(negedge clock);
   endtask

   task automatic run_sequence();
      int                       ch;
      int                       reqs;
      int unsigned              len;
      logic [SIZE_BITS-1:0]     src_sz;
      logic [FIELD_COUNT_W-1:0] count;
      logic [FIELD_ADDR_W-1:0]  src;
      logic [FIELD_ADDR_W-1:0]  dst;
      ch     = $urandom_range(0, NCHAN - 1);
      src_sz = SIZE_BITS'($urandom_range(0, 3));
      count  = ($urandom_range(0, 9) == 0) ? FIELD_COUNT_W'($urandom_range(0, 16'hFFFF))
                                            : FIELD_COUNT_W'($urandom_range(1, 48));
      src    = ($urandom_range(0, 4) == 0) ? (32'hFFFF_FFC0 | $urandom_range(0, 63))
                                            : $urandom;
      dst    = ($urandom_range(0, 4) == 0) ? (32'hFFFF_FFC0 | $urandom_range(0, 63))
                                            : $urandom;
      send(make_setup(ch, src, dst, count, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), src_sz, SIZE_BITS'($urandom_range(0, 3)),
                      1'($urandom_range(0, 1))));
      if ($urandom_range(0, 1) == 1) begin
         send(make_cmd(CMD_ENABLE, ch));
      end
      send(make_cmd(CMD_START, ch));
      len  = (src_sz == SIZE_BYTE) ? 1 : (src_sz == SIZE_HALF) ? 2 : 4;
      reqs = count / len;
      if (reqs > 24) begin
         reqs = 24;
      end
      reqs += $urandom_range(0, 3);
      repeat (reqs) begin
         if ($urandom_range(0, 7) == 0) begin
            send(noise_item());
         end
         send(make_cmd(CMD_REQUEST, ch));
      end
      if ($urandom_range(0, 1) == 1) begin
         send(make_cmd(CMD_QUERY, ch));
      end
   endtask

   initial begin : receiver
      rx_mode_type mode;
      int          span;
      int          period;
      int          tick;
      bit          held_off;
      held_off  = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         if (!held_off && sent >= 400) begin
            held_off = 1'b1;
            repeat (HOLD_CYCLES) begin
               @(negedge clock);
               rsp_ready <= 1'b0;
            end
         end
         mode   = rx_mode_type'($urandom_range(0, 3));
         span   = $urandom_range(20, 120);
         period = $urandom_range(2, 7);
         for (tick = 0; tick < span; tick++) begin
            @(negedge clock);
            case (mode)
               RX_FREE:     rsp_ready <= 1'b1;
               RX_COIN:     rsp_ready <= 1'($urandom_range(0, 1));
               RX_PERIODIC: rsp_ready <= (tick % period) != 0;
               default:     rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   initial begin : stimulus
      dma_command_type c;
      int              directed;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_command       = CMD_QUERY;
      req_channel       = '0;
      req_src_addr      = '0;
      req_dst_addr      = '0;
      req_byte_count    = '0;
      req_src_increment = 1'b0;
      req_dst_increment = 1'b0;
      req_src_size      = SIZE_BYTE;
      req_dst_size      = SIZE_BYTE;
      req_start_now     = 1'b0;
      req_notify_enable = 1'b0;
      foreach (cmd_seen[i]) cmd_seen[i] = 0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      send(make_cmd(CMD_QUERY, 0));
      send(make_setup(0, '0, '0, 16'd8, 1'b1, 1'b1, SIZE_WORD, SIZE_WORD, 1'b1));
      send(make_cmd(CMD_START, 0));
      send(make_setup(15, 32'h10, 32'h20, 16'd4, 1'b1, 1'b1, SIZE_BYTE, SIZE_BYTE, 1'b0));
      send(make_cmd(CMD_REQUEST, NCHAN));
      send(make_cmd(CMD_CLEAR_ALL, 15));
      // Size code three on the source, both pointers wrapping past the top.
      send(make_setup(0, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 16'd6, 1'b1, 1'b1, 2'd3, SIZE_HALF,
                      1'b1));
      send(make_cmd(CMD_ENABLE, 0));
      c               = make_cmd(CMD_START, 0);
      c.notify_enable = 1'b1;
      send(c);
      repeat (3) send(make_cmd(CMD_REQUEST, 0));
      send(make_cmd(CMD_QUERY, 0));
      repeat (2) send(make_cmd(CMD_CLAIM, 1));
      send(make_cmd(CMD_DISABLE, 1));
      send(make_setup(3, 32'h1, '0, 16'hFFFF, 1'b0, 1'b0, SIZE_BYTE, SIZE_WORD, 1'b0));
      c               = make_cmd(CMD_START, 3);
      c.notify_enable = 1'b0;
      send(c);
      send(make_cmd(CMD_REQUEST, 3));
      repeat (2) send(make_cmd(CMD_REQUEST, 2));
      send(make_cmd(CMD_QUERY, 3));
      send(make_setup(1, '0, 32'hFFFF_FFFF, 16'd1, 1'b1, 1'b1, SIZE_HALF, SIZE_BYTE, 1'b0));
      c               = make_cmd(CMD_START, 1);
      c.notify_enable = 1'b1;
      send(c);
      send(make_cmd(CMD_CLEAR_ALL, 0));
      send(make_cmd(CMD_QUERY, 1));
      directed = sent;

      while (sent < directed + ITEMS) begin
         if ($urandom_range(0, 3) != 0) begin
            run_sequence();
         end else begin
            send(noise_item());
         end
      end
      req_valid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Run covered %0d commands: %0d set, %0d start, %0d request,",
               sent, cmd_seen[CMD_SET_TRANSFER], cmd_seen[CMD_START],
               cmd_seen[CMD_REQUEST]);
      $display("%0d claim, %0d query, %0d clear all; %0d responses checked,",
               cmd_seen[CMD_CLAIM], cmd_seen[CMD_QUERY], cmd_seen[CMD_CLEAR_ALL], checked);
      $display("%0d unit transfers, %0d completion notices, %0d mismatches.",
               units_issued, notices, fail_count);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
